FILE: rtl/clnws_pkg.sv
// clnws_pkg: shared types, codes and pin-state tables for the LCD nibble
// write sequencer. No dependencies.
package clnws_pkg;

   localparam int PULSE_W = 10;
   localparam int HOLD_W  = 20;
   localparam int STEP_W  = 5;

   // request codes
   localparam logic [1:0] CMD_WRITE_INSTR = 2'd0;
   localparam logic [1:0] CMD_WRITE_DATA  = 2'd1;
   localparam logic [1:0] CMD_INIT        = 2'd2;

   // register indexes
   localparam logic CSR_ENABLE_PULSE = 1'b0;
   localparam logic CSR_POWER_WAIT   = 1'b1;

   localparam logic [PULSE_W-1:0] ENABLE_PULSE_RESET = 10'd1;
   localparam logic [HOLD_W-1:0]  POWER_WAIT_RESET   = 20'd40000;

   localparam logic [HOLD_W-1:0] SLOW_WAIT_US = 20'd2000;
   localparam logic [HOLD_W-1:0] WAKE_WAIT_US = 20'd6000;

   localparam logic [7:0] INSTR_CLEAR   = 8'h01;
   localparam logic [7:0] INSTR_FUNCSET = 8'h28;
   localparam logic [7:0] INSTR_DISPON  = 8'h0C;
   localparam logic [7:0] INSTR_ENTRY   = 8'h06;

   localparam logic [3:0] WAKE_NIBBLE = 4'h3;
   localparam logic [3:0] MODE_NIBBLE = 4'h2;

   localparam logic [STEP_W-1:0] WRITE_LAST_STEP = 5'd3;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 5'd24;
   localparam logic [STEP_W-1:0] INIT_BYTE_START = 5'd9;

   typedef enum logic [1:0] {
      EXTRA_NONE  = 2'd0,
      EXTRA_SLOW  = 2'd1,
      EXTRA_WAKE  = 2'd2,
      EXTRA_POWER = 2'd3
   } extra_type;

   typedef struct packed {
      logic            en;
      logic [3:0]      nib;
      extra_type       extra;
      logic            last;
   } step_info_type;

   // controller -> datapath
   typedef struct packed {
      logic              load_req;
      logic              emit;
      logic              sel_init;
      logic [STEP_W-1:0] step;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } dp_status_type;

   // One of the four pin states of a byte write.
   function automatic step_info_type write_step(input logic [1:0] idx,
                                                input logic slow,
                                                input logic last_en,
                                                input logic [7:0] b);
      step_info_type s;
      s.en    = ~idx[0];
      s.nib   = idx[1] ? b[3:0] : b[7:4];
      s.extra = (idx == 2'd3 && slow) ? EXTRA_SLOW : EXTRA_NONE;
      s.last  = (idx == 2'd3) ? last_en : 1'b0;
      return s;
   endfunction

   // Power-on sequence, 25 pin states.
   function automatic step_info_type init_step(input logic [STEP_W-1:0] idx);
      step_info_type s;
      logic [STEP_W-1:0] k;
      logic [7:0] b;
      k = idx - INIT_BYTE_START;
      unique case (k[3:2])
         2'd0:    b = INSTR_FUNCSET;
         2'd1:    b = INSTR_DISPON;
         2'd2:    b = INSTR_CLEAR;
         default: b = INSTR_ENTRY;
      endcase
      if (idx == '0) begin
         s.en    = 1'b0;
         s.nib   = 4'h0;
         s.extra = EXTRA_POWER;
         s.last  = 1'b0;
      end else if (idx < 5'd7) begin
         s.en    = idx[0];
         s.nib   = WAKE_NIBBLE;
         s.extra = idx[0] ? EXTRA_NONE : EXTRA_WAKE;
         s.last  = 1'b0;
      end else if (idx < INIT_BYTE_START) begin
         s.en    = idx[0];
         s.nib   = MODE_NIBBLE;
         s.extra = EXTRA_NONE;
         s.last  = 1'b0;
      end else begin
         // clear and entry mode both carry the slow wait
         s = write_step(k[1:0], k[3], idx == INIT_LAST_STEP, b);
      end
      return s;
   endfunction

endpackage

FILE: rtl/clnws_if.sv
// clnws_if: request and response channel interfaces (valid/ready).
// Depends on clnws_pkg.
interface clnws_req_if
   import clnws_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] byte_value;

   modport source (output valid, command, byte_value, input ready);
   modport sink   (input valid, command, byte_value, output ready);
endinterface

interface clnws_rsp_if
   import clnws_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              rs_level;
   logic              enable_level;
   logic [3:0]        bus_nibble;
   logic [HOLD_W-1:0] hold_us;
   logic              last_step;

   modport source (output valid, rs_level, enable_level, bus_nibble, hold_us,
                   last_step, input ready);
   modport sink   (input valid, rs_level, enable_level, bus_nibble, hold_us,
                   last_step, output ready);
endinterface

FILE: rtl/clnws_ctrl.sv
// clnws_ctrl: request handshake and step sequencing state machine.
// Depends on clnws_pkg.
module clnws_ctrl
   import clnws_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_command,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WRITE = 3'b010,
      ST_INIT  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              emit, last, accept;

   assign emit   = (state_ff != ST_IDLE) && status.out_free;
   assign last   = ((state_ff == ST_WRITE) && (step_ff == WRITE_LAST_STEP)) ||
                   ((state_ff == ST_INIT) && (step_ff == INIT_LAST_STEP));
   // next request is taken together with the final pin state
   assign req_ready = (state_ff == ST_IDLE) || (emit && last);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      if (accept) begin
         step_in = '0;
         unique case (req_command)
            CMD_WRITE_INSTR, CMD_WRITE_DATA: state_in = ST_WRITE;
            CMD_INIT:                        state_in = ST_INIT;
            default:                         state_in = ST_IDLE;
         endcase
      end else if (emit) begin
         if (last) begin
            state_in = ST_IDLE;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign cmd.load_req = accept;
   assign cmd.emit     = emit;
   assign cmd.sel_init = (state_ff == ST_INIT);
   assign cmd.step     = step_ff;

endmodule

FILE: rtl/clnws_dpath.sv
// clnws_dpath: config registers, request latch, pin-state decode and
// output register. Depends on clnws_pkg.
module clnws_dpath
   import clnws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [HOLD_W-1:0] csr_write_data,
   input  logic [1:0]        req_command,
   input  logic [7:0]        req_byte_value,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              rsp_rs_level,
   output logic              rsp_enable_level,
   output logic [3:0]        rsp_bus_nibble,
   output logic [HOLD_W-1:0] rsp_hold_us,
   output logic              rsp_last_step,
   input  dp_cmd_type        cmd,
   output dp_status_type     status
);

   logic [PULSE_W-1:0] pulse_ff;
   logic [HOLD_W-1:0]  power_ff;
   logic               rs_ff;
   logic [7:0]         byte_ff;
   logic               valid_ff, valid_in;
   logic               rs_out_ff, en_out_ff, last_out_ff;
   logic [3:0]         nib_out_ff;
   logic [HOLD_W-1:0]  hold_out_ff, hold_in;
   step_info_type      info;
   logic               slow;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff <= ENABLE_PULSE_RESET;
         power_ff <= POWER_WAIT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_ENABLE_PULSE) begin
            pulse_ff <= csr_write_data[PULSE_W-1:0];
         end else begin
            power_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rs_ff   <= req_command[0];
         byte_ff <= req_byte_value;
      end
   end

   // clear (0x01) and home (0x02/0x03) instructions need the slow wait
   assign slow = !rs_ff && ((byte_ff == INSTR_CLEAR) || (byte_ff[7:1] == 7'd1));

   always_comb begin
      if (cmd.sel_init) begin
         info = init_step(cmd.step);
      end else begin
         info = write_step(cmd.step[1:0], slow, 1'b1, byte_ff);
      end
      unique case (info.extra)
         EXTRA_NONE:  hold_in = {{(HOLD_W-PULSE_W){1'b0}}, pulse_ff};
         EXTRA_SLOW:  hold_in = {{(HOLD_W-PULSE_W){1'b0}}, pulse_ff} + SLOW_WAIT_US;
         EXTRA_WAKE:  hold_in = {{(HOLD_W-PULSE_W){1'b0}}, pulse_ff} + WAKE_WAIT_US;
         default:     hold_in = power_ff;
      endcase
   end

   assign status.out_free = !valid_ff || rsp_ready;

   always_comb begin
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rs_out_ff   <= cmd.sel_init ? 1'b0 : rs_ff;
         en_out_ff   <= info.en;
         nib_out_ff  <= info.nib;
         hold_out_ff <= hold_in;
         last_out_ff <= info.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_rs_level     = rs_out_ff;
   assign rsp_enable_level = en_out_ff;
   assign rsp_bus_nibble   = nib_out_ff;
   assign rsp_hold_us      = hold_out_ff;
   assign rsp_last_step    = last_out_ff;

endmodule

FILE: rtl/char_lcd_nibble_write_sequencer.sv
// char_lcd_nibble_write_sequencer: top level, controller plus datapath.
// Depends on clnws_pkg, clnws_if, clnws_ctrl and clnws_dpath.
//
// Turns requests for a 4-bit HD44780-style character LCD into a list of pin
// states, one response beat per state: RS level, enable level, D7..D4 and a
// hold time in microseconds, with last_step set on the final state of the
// request. The block does no timing of its own; the consumer holds each
// state for hold_us. An instruction or data write gives 4 beats (high nibble
// then low nibble, enable high then low for each); clear and home
// instructions add 2000 us to the final hold. An init request gives 25 beats
// (power-on wait, three 0x3 wake pulses with 6000 us each, 0x2, then 0x28,
// 0x0C, 0x01 and 0x06). Command code 3 is consumed with no beats. Rate: one
// beat per cycle while the response side is ready; the step counter of the
// controller sets the pace, and the next request is accepted in the cycle
// its predecessor's final beat is produced. A finished beat waits in the
// output register without blocking that acceptance. Config (enable_pulse_us
// index 0, power_on_wait_us index 1) is to be written through the csr_ port
// only while the block is idle; the block itself does not enforce this.
module char_lcd_nibble_write_sequencer
   import clnws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [HOLD_W-1:0] csr_write_data,
   clnws_req_if.sink         req_chan,
   clnws_rsp_if.source       rsp_chan
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencing: handshake on the request side, step counter
   clnws_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .status      (dp_status),
      .cmd         (dp_cmd)
   );

   // config, pin-state decode and response register
   clnws_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_command      (req_chan.command),
      .req_byte_value   (req_chan.byte_value),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_rs_level     (rsp_chan.rs_level),
      .rsp_enable_level (rsp_chan.enable_level),
      .rsp_bus_nibble   (rsp_chan.bus_nibble),
      .rsp_hold_us      (rsp_chan.hold_us),
      .rsp_last_step    (rsp_chan.last_step),
      .cmd              (dp_cmd),
      .status           (dp_status)
   );

endmodule
